>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both macros assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AST_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AST_PROP(lbl, prop, msg)
`define AST_NEVER(lbl, cond, msg)
`endif
`endif

>>> src/pdts_pkg.sv
package pdts_pkg;

  localparam int PENDING_DEPTH_DEF = 16;
  localparam int RUNNING_DEPTH_DEF = 8;
  localparam logic [3:0] MAX_RUNNING_RST = 4'd8;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_SCHED  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_QUERY  = 2'd3
  } pdts_op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  task_kind;
    logic [15:0] task_priority;
    logic [31:0] deadline;
    logic [4:0]  target_id;
  } in_item_t;

  typedef struct packed {
    logic       op_ok;
    logic [4:0] assigned_id;
    logic       is_running;
    logic [4:0] pending_count;
    logic [3:0] running_count;
  } out_item_t;

  // One pending entry.
  typedef struct packed {
    logic [4:0]  id;
    logic [3:0]  kind;
    logic [15:0] prio;
    logic [31:0] dl;
  } pend_ent_t;

  // One running entry carries the running mark as well.
  typedef struct packed {
    pend_ent_t ent;
    logic      mark;
  } run_ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCH_FIND,
    ST_CAN_P,
    ST_CAN_R,
    ST_PROMO,
    ST_COMPACT,
    ST_QRY,
    ST_FIN
  } pdts_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic pidx_inc;
    logic ridx_inc;
    logic ins;
    logic p_remove;
    logic r_clr;
    logic promote;
    logic compact;
    logic r_fin;
    logic set_run;
    logic load_out;
  } pdts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic p_end;
    logic p_before;
    logic p_match;
    logic p_full;
    logic r_end;
    logic r_match;
    logic can_promote;
    logic out_free;
  } pdts_sts_t;

endpackage

>>> src/priority_deadline_task_scheduler.sv
// A schedule to a list that is not full, or a cancel, walks the pending list one entry a cycle,
// a cancel miss then the running list; a query walks the running list; a tick moves one task
// a cycle, then compacts the running list one a cycle. The result waits while the output stalls.
// One item at a time: the next is taken the cycle after the result is loaded.
// Reset (rst_n, synchronous, active low) empties both lists and sets the limit to 8.
`include "assert_macros.svh"
module priority_deadline_task_scheduler import pdts_pkg::*; #(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int RUNNING_DEPTH = RUNNING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  pdts_cmd_t  cmd;
  pdts_sts_t  sts;
  logic [5:0] moves;

  // Sequencer.
  pdts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Lists, counters and output register.
  pdts_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .RUNNING_DEPTH (RUNNING_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  // List commands that must never coincide.
  assign moves = {cmd.ins, cmd.p_remove, cmd.r_clr, cmd.promote, cmd.compact, cmd.set_run};

  `AST_PROP(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "no stall after accept")
  `AST_PROP(a_load_shows, cmd.load_out |=> out_valid, "loaded result not shown")
  `AST_NEVER(a_ins_full, cmd.ins && sts.p_full, "insert into a full pending list")
  `AST_PROP(a_one_move, $onehot0(moves), "conflicting list commands")

endmodule

>>> src/pdts_ctrl.sv
module pdts_ctrl import pdts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_stall,
  input  pdts_sts_t  sts,
  output pdts_cmd_t  cmd
);

  pdts_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (pdts_op_t'(in_op))
            OP_SCHED:  state_nxt = sts.p_full ? ST_FIN : ST_SCH_FIND;
            OP_CANCEL: state_nxt = ST_CAN_P;
            OP_TICK:   state_nxt = ST_PROMO;
            OP_QUERY:  state_nxt = ST_QRY;
            default:   state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SCH_FIND: begin
        if (sts.p_end || sts.p_before) state_nxt = ST_FIN;
      end
      ST_CAN_P: begin
        if (sts.p_end) state_nxt = ST_CAN_R;
        else if (sts.p_match) state_nxt = ST_FIN;
      end
      ST_CAN_R: begin
        if (sts.r_end || sts.r_match) state_nxt = ST_FIN;
      end
      ST_PROMO: begin
        if (!sts.can_promote) state_nxt = ST_COMPACT;
      end
      ST_COMPACT: begin
        if (sts.r_end) state_nxt = ST_FIN;
      end
      ST_QRY: begin
        if (sts.r_end || sts.r_match) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: cmd.start = in_valid;
      ST_SCH_FIND: begin
        if (sts.p_end || sts.p_before) cmd.ins = 1'b1;
        else cmd.pidx_inc = 1'b1;
      end
      ST_CAN_P: begin
        if (!sts.p_end) begin
          if (sts.p_match) cmd.p_remove = 1'b1;
          else cmd.pidx_inc = 1'b1;
        end
      end
      ST_CAN_R: begin
        if (!sts.r_end) begin
          if (sts.r_match) cmd.r_clr = 1'b1;
          else cmd.ridx_inc = 1'b1;
        end
      end
      ST_PROMO: cmd.promote = sts.can_promote;
      ST_COMPACT: begin
        if (sts.r_end) cmd.r_fin = 1'b1;
        else cmd.compact = 1'b1;
      end
      ST_QRY: begin
        if (!sts.r_end) begin
          if (sts.r_match) cmd.set_run = 1'b1;
          else cmd.ridx_inc = 1'b1;
        end
      end
      ST_FIN: cmd.load_out = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> src/pdts_datapath.sv
module pdts_datapath import pdts_pkg::*; #(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int RUNNING_DEPTH = RUNNING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  in_item_t   in_data,
  input  pdts_cmd_t  cmd,
  output pdts_sts_t  sts,
  input  logic       out_stall,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int PIW = $clog2(PENDING_DEPTH);
  localparam int RCW = $clog2(RUNNING_DEPTH + 1);
  localparam int RIW = (RUNNING_DEPTH > 1) ? $clog2(RUNNING_DEPTH) : 1;

  logic [3:0]     max_run_r;
  logic [PCW-1:0] psize_r, pidx_r;
  logic [RCW-1:0] rsize_r, ridx_r, wptr_r;
  logic           ok_r, qrun_r;
  logic [4:0]     aid_r;
  in_item_t       fld_r;
  pend_ent_t      pend_r   [PENDING_DEPTH];
  pend_ent_t      pend_nxt [PENDING_DEPTH];
  run_ent_t       runl_r   [RUNNING_DEPTH];
  run_ent_t       runl_nxt [RUNNING_DEPTH];
  logic           out_valid_r;
  out_item_t      out_data_r;

  pend_ent_t  p_ent, new_ent;
  run_ent_t   r_ent;
  logic [4:0] new_id;
  logic [7:0] lim;

  // Entries under the scan pointers and the item being scheduled.
  assign p_ent   = pend_r[pidx_r[PIW-1:0]];
  assign r_ent   = runl_r[ridx_r[RIW-1:0]];
  assign new_id  = 5'(psize_r) + 5'(rsize_r) + 5'd1;
  assign new_ent = '{id: new_id, kind: fld_r.task_kind, prio: fld_r.task_priority,
                     dl: fld_r.deadline};

  // The running limit is saturated at the list depth.
  assign lim = ({4'b0, max_run_r} > 8'(RUNNING_DEPTH)) ? 8'(RUNNING_DEPTH)
                                                       : {4'b0, max_run_r};

  // Status towards the controller.
  always_comb begin
    sts.p_end       = (pidx_r == psize_r);
    sts.p_before    = (fld_r.task_priority > p_ent.prio) ||
                      ((fld_r.task_priority == p_ent.prio) && (fld_r.deadline < p_ent.dl));
    sts.p_match     = (p_ent.id == fld_r.target_id);
    sts.p_full      = (psize_r == PCW'(PENDING_DEPTH));
    sts.r_end       = (ridx_r == rsize_r);
    sts.r_match     = (r_ent.ent.id == fld_r.target_id);
    sts.can_promote = (8'(rsize_r) < lim) && (psize_r != '0);
    sts.out_free    = !out_valid_r || !out_stall;
  end

  // Per-entry moves of both lists: insertion, removal, promotion and compaction.
  always_comb begin
    pend_nxt = pend_r;
    runl_nxt = runl_r;
    for (int j = 0; j < PENDING_DEPTH; j++) begin
      if (cmd.ins) begin
        if ((PCW'(j) > pidx_r) && (PCW'(j) <= psize_r)) begin
          pend_nxt[j] = pend_r[(j > 0) ? j - 1 : 0];
        end
        if (PCW'(j) == pidx_r) pend_nxt[j] = new_ent;
      end
      if ((cmd.p_remove && (PCW'(j) >= pidx_r)) || cmd.promote) begin
        pend_nxt[j] = pend_r[(j < PENDING_DEPTH - 1) ? j + 1 : j];
      end
    end
    if (cmd.r_clr) runl_nxt[ridx_r[RIW-1:0]].mark = 1'b0;
    if (cmd.promote) runl_nxt[rsize_r[RIW-1:0]] = '{ent: pend_r[0], mark: 1'b1};
    if (cmd.compact && r_ent.mark) runl_nxt[wptr_r[RIW-1:0]] = r_ent;
  end

  // List storage.
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    runl_r <= runl_nxt;
  end

  // Sizes, configuration and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_run_r   <= MAX_RUNNING_RST;
      psize_r     <= '0;
      rsize_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) max_run_r <= cfg_wr_data;
      if (cmd.ins) psize_r <= psize_r + PCW'(1);
      else if (cmd.p_remove || cmd.promote) psize_r <= psize_r - PCW'(1);
      if (cmd.promote) rsize_r <= rsize_r + RCW'(1);
      else if (cmd.r_fin) rsize_r <= wptr_r;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Item fields, scan pointers and result flags.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      fld_r  <= in_data;
      pidx_r <= '0;
      ridx_r <= '0;
      wptr_r <= '0;
      ok_r   <= 1'b0;
      qrun_r <= 1'b0;
      aid_r  <= '0;
    end else begin
      if (cmd.pidx_inc) pidx_r <= pidx_r + PCW'(1);
      if (cmd.ridx_inc || cmd.compact) ridx_r <= ridx_r + RCW'(1);
      if (cmd.compact && r_ent.mark) wptr_r <= wptr_r + RCW'(1);
      if (cmd.ins || cmd.p_remove || cmd.r_clr || cmd.r_fin) ok_r <= 1'b1;
      if (cmd.ins) aid_r <= new_id;
      if (cmd.set_run) qrun_r <= r_ent.mark;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.op_ok         <= ok_r;
      out_data_r.assigned_id   <= aid_r;
      out_data_r.is_running    <= qrun_r;
      out_data_r.pending_count <= 5'(psize_r);
      out_data_r.running_count <= 4'(rsize_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> bench/pdts_checker.sv
`timescale 1ns / 100ps
module pdts_checker import pdts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        waiting
);

  localparam int PD = PENDING_DEPTH_DEF;
  localparam int RD = RUNNING_DEPTH_DEF;

  // Model copy of the scheduler state.
  pend_ent_t   pend_q[$];
  run_ent_t    run_q[$];
  logic [3:0]  run_limit;
  out_item_t   due_q[$];

  // Work out the result of one item and update the model lists.
  function automatic out_item_t schedule_step(in_item_t it);
    out_item_t r;
    pend_ent_t e;
    run_ent_t re;
    int pos;
    int lim;
    bit found;
    r = '0;
    found = 0;
    case (pdts_op_t'(it.operation))
      OP_SCHED: begin
        if (pend_q.size() < PD) begin
          e.id = 5'(pend_q.size() + run_q.size() + 1);
          e.kind = it.task_kind;
          e.prio = it.task_priority;
          e.dl = it.deadline;
          pos = 0;
          // Equal entries stay ahead of the newcomer.
          while (pos < pend_q.size() && !(e.prio > pend_q[pos].prio ||
                 (e.prio == pend_q[pos].prio && e.dl < pend_q[pos].dl)))
            pos++;
          pend_q.insert(pos, e);
          r.op_ok = 1'b1;
          r.assigned_id = e.id;
        end
      end
      OP_CANCEL: begin
        foreach (pend_q[i]) begin
          if (!found && pend_q[i].id == it.target_id) begin
            pend_q.delete(i);
            found = 1;
            break;
          end
        end
        if (!found) begin
          foreach (run_q[i]) begin
            if (!found && run_q[i].ent.id == it.target_id) begin
              run_q[i].mark = 1'b0;
              found = 1;
            end
          end
        end
        r.op_ok = found;
      end
      OP_TICK: begin
        lim = (run_limit > RD) ? RD : run_limit;
        while (run_q.size() < lim && pend_q.size() > 0) begin
          re.ent = pend_q.pop_front();
          re.mark = 1'b1;
          run_q.insert(run_q.size(), re);
        end
        for (int i = run_q.size() - 1; i >= 0; i--)
          if (!run_q[i].mark) run_q.delete(i);
        r.op_ok = 1'b1;
      end
      default: begin
        foreach (run_q[i]) begin
          if (!found && run_q[i].ent.id == it.target_id) begin
            r.is_running = run_q[i].mark;
            found = 1;
          end
        end
      end
    endcase
    r.pending_count = 5'(pend_q.size());
    r.running_count = 4'(run_q.size());
    return r;
  endfunction

  assign waiting = due_q.size();

  // Predict on each accepted item, compare each accepted result.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pend_q.delete();
      run_q.delete();
      due_q.delete();
      run_limit <= MAX_RUNNING_RST;
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) run_limit <= cfg_wr_data;
      if (in_valid && !in_stall) due_q.insert(due_q.size(), schedule_step(in_data));
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $error("result with no item outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = due_q.pop_front();
          if (want !== out_data) begin
            if (want.op_ok !== out_data.op_ok)
              $error("op_ok: expected %0d, got %0d", want.op_ok, out_data.op_ok);
            if (want.assigned_id !== out_data.assigned_id)
              $error("assigned_id: expected %0d, got %0d",
                     want.assigned_id, out_data.assigned_id);
            if (want.is_running !== out_data.is_running)
              $error("is_running: expected %0d, got %0d",
                     want.is_running, out_data.is_running);
            if (want.pending_count !== out_data.pending_count)
              $error("pending_count: expected %0d, got %0d",
                     want.pending_count, out_data.pending_count);
            if (want.running_count !== out_data.running_count)
              $error("running_count: expected %0d, got %0d",
                     want.running_count, out_data.running_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> bench/priority_deadline_task_scheduler_tb.sv
`timescale 1ns / 100ps
module priority_deadline_task_scheduler_tb;
  import pdts_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = 40;

  logic      clk;
  logic      rst_n;
  logic      cfg_wr_en;
  logic [3:0] cfg_wr_data;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        waiting;
  int        quiet_cycles;
  bit        hold_off;
  bit        stall_on;

  priority_deadline_task_scheduler DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  pdts_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .waiting(waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int mode;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_stall <= 1'b1;
      else if (!stall_on) out_stall <= 1'b0;
      else begin
        mode = $urandom_range(0, 3);
        out_stall <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 1) == 1) : 1'b0;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one item and wait until it is taken; valid is left to the caller.
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random item; schedules dominate so the lists fill, and ticks drain them.
  function automatic in_item_t rand_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 9);
    it.operation = (pick < 4) ? OP_SCHED : (pick < 6) ? OP_TICK :
                   (pick < 8) ? OP_CANCEL : OP_QUERY;
    it.task_kind = 4'($urandom);
    // Narrow ranges give many equal priorities and deadlines.
    it.task_priority = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    it.deadline = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 3)) : $urandom;
    it.target_id = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 25));
    return it;
  endfunction

  task automatic drain_and_write(logic [3:0] lim);
    in_valid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lim;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    in_item_t it;
    int gap;
    logic [3:0] limits [6];
    limits = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd5};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    hold_off = 1'b0;
    stall_on = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, a full pending list, misses and the tick paths.
    it = '0;
    it.operation = OP_QUERY; send_item(it);
    it.operation = OP_CANCEL; it.target_id = 5'd31; send_item(it);
    it.operation = OP_TICK; send_item(it);
    for (int i = 0; i < 17; i++) begin
      it.operation = OP_SCHED;
      it.task_kind = (i % 2) ? 4'hF : 4'h0;
      it.task_priority = (i < 6) ? 16'hFFFF : (i < 10) ? 16'h0 : 16'd7;
      it.deadline = (i % 3 == 0) ? 32'hFFFF_FFFF : 32'h0;
      send_item(it);
    end
    it.operation = OP_CANCEL; it.target_id = 5'd3; send_item(it);
    it.operation = OP_TICK; send_item(it);
    it.operation = OP_CANCEL; it.target_id = 5'd1; send_item(it);
    it.operation = OP_QUERY; it.target_id = 5'd1; send_item(it);
    it.operation = OP_QUERY; it.target_id = 5'd2; send_item(it);

    // Random phases, each under its own limit.
    stall_on = 1'b1;
    foreach (limits[p]) begin
      drain_and_write(limits[p]);
      for (int n = 0; n < 180; n++) begin
        // The receiver holds off for a counted stretch while items keep coming.
        if (p == 2 && n == 20) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (300) @(negedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        send_item(rand_item());
        if ($urandom_range(0, 3) == 0) begin
          gap = $urandom_range(1, 30);
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
